### hdl/cln_pkg.sv
// shared types, codes and constants of the character-lcd nibble sequencer
package cln_pkg;

  // field widths
  localparam int CMD_W    = 3;
  localparam int BYTE_W   = 8;
  localparam int ROW_W    = 2;
  localparam int COL_W    = 6;
  localparam int CNT_W    = 6;
  localparam int NIB_W    = 4;
  localparam int PRE_W    = 5;
  localparam int POST_W   = 3;

  // defaults for top-level parameters
  localparam int MAX_SHIFT_DEF   = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  // request codes
  typedef enum logic [CMD_W-1:0] {
    CMD_INSTR  = 3'd0,
    CMD_DATA   = 3'd1,
    CMD_CURSOR = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_SHIFT  = 3'd4,
    CMD_INIT   = 3'd5
  } cmd_t;

  // lcd instruction bytes
  localparam logic [BYTE_W-1:0] LCD_SET_DDRAM  = 8'h80;
  localparam logic [BYTE_W-1:0] LCD_ROW2_OFS   = 8'h40;
  localparam logic [BYTE_W-1:0] LCD_SHIFT_BASE = 8'h18;
  localparam logic [BYTE_W-1:0] LCD_CLEAR      = 8'h01;

  // rows that address the display
  localparam logic [ROW_W-1:0] ROW_FIRST  = 2'd1;
  localparam logic [ROW_W-1:0] ROW_SECOND = 2'd2;

  // init run: wake-up bytes followed by the setup bytes
  localparam logic [CNT_W-1:0] INIT_LEN  = 6'd10;
  localparam logic [CNT_W-1:0] INIT_WAKE = 6'd4;

  // waits in milliseconds
  localparam logic [PRE_W-1:0]  PRE_INIT_MS  = 5'd30;
  localparam logic [PRE_W-1:0]  PRE_NONE_MS  = 5'd0;
  localparam logic [POST_W-1:0] POST_MS      = 3'd2;
  localparam logic [POST_W-1:0] POST_WAKE_MS = 3'd7;

  // one queued job: a byte sent reps times, or the init run
  typedef struct packed {
    logic              init;
    logic              rs;
    logic [BYTE_W-1:0] value;
    logic [CNT_W-1:0]  reps;
  } desc_t;

  // byte of the init run at a position
  function automatic logic [BYTE_W-1:0] init_byte(input logic [3:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx) inside
      [4'd0:4'd3]: b = 8'h03;
      4'd4:        b = 8'h02;
      4'd5:        b = 8'h28;
      4'd6:        b = 8'h08;
      4'd7:        b = 8'h0F;
      4'd8:        b = 8'h06;
      4'd9:        b = 8'h01;
      default:     b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### hdl/cln_front.sv
// request front end: takes requests and turns them into queued jobs
module cln_front
  import cln_pkg::*;
#(
  parameter int MAX_SHIFT = MAX_SHIFT_DEF
) (
  input  logic              in_push,
  output logic              in_full,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [BYTE_W-1:0] in_value,
  input  logic [ROW_W-1:0]  in_row,
  input  logic [COL_W-1:0]  in_column,
  input  logic [CNT_W-1:0]  in_shift_count,
  input  logic              in_direction,
  input  logic              q_full,
  output logic              q_push,
  output desc_t             q_data
);

  logic              has_out;
  logic [BYTE_W-1:0] addr;
  logic [CNT_W-1:0]  sat_count;

  // cursor address wraps modulo 256
  always_comb begin
    addr = {{(BYTE_W-COL_W){1'b0}}, in_column} + 8'hFF;
    if (in_row == ROW_SECOND) begin
      addr = addr + LCD_ROW2_OFS;
    end
  end

  // shift count saturation
  assign sat_count = (in_shift_count > CNT_W'(MAX_SHIFT)) ? CNT_W'(MAX_SHIFT)
                                                          : in_shift_count;

  // classify the request
  always_comb begin
    has_out      = 1'b1;
    q_data.init  = 1'b0;
    q_data.rs    = 1'b0;
    q_data.value = in_value;
    q_data.reps  = 6'd1;
    case (cmd_t'(in_command))
      CMD_INSTR: begin
      end
      CMD_DATA: begin
        q_data.rs = 1'b1;
      end
      CMD_CURSOR: begin
        q_data.value = LCD_SET_DDRAM | addr;
        has_out      = (in_row == ROW_FIRST) || (in_row == ROW_SECOND);
      end
      CMD_CLEAR: begin
        q_data.value = LCD_CLEAR;
      end
      CMD_SHIFT: begin
        q_data.value = LCD_SHIFT_BASE | {5'd0, in_direction, 2'd0};
        q_data.reps  = sat_count;
        has_out      = (sat_count != '0);
      end
      CMD_INIT: begin
        q_data.init = 1'b1;
        q_data.reps = INIT_LEN;
      end
      default: begin
        has_out = 1'b0;
      end
    endcase
  end

  // requests with no output are taken and dropped
  assign in_full = q_full;
  assign q_push  = in_push && !q_full && has_out;

endmodule

### hdl/cln_queue.sv
// short job queue between front end and nibble generator
module cln_queue
  import cln_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t wdata,
  output logic  full,
  input  logic  pop,
  output desc_t rdata,
  output logic  empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  desc_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  // pointer and fill count update
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

### hdl/cln_back.sv
// nibble generator: expands one job into enable-pulse results
module cln_back
  import cln_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  desc_t             q_data,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output logic              out_register_select,
  output logic [NIB_W-1:0]  out_nibble,
  output logic [PRE_W-1:0]  out_pre_wait_ms,
  output logic [POST_W-1:0] out_post_wait_ms,
  output logic              out_last
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  desc_t             cur_r, cur_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic              half_r, half_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic              emit;
  logic              fin;
  logic [BYTE_W-1:0] cur_byte;
  logic              rs_r;
  logic [NIB_W-1:0]  nib_r;
  logic [PRE_W-1:0]  pre_r;
  logic [POST_W-1:0] post_r;
  logic              last_r;

  // current byte and end of run
  assign cur_byte = cur_r.init ? init_byte(pos_r[3:0]) : cur_r.value;
  assign fin      = half_r && (pos_r == cur_r.reps - 1'b1);

  // output register loads when empty or being taken
  assign emit  = (state_r == ST_RUN) && (!ovalid_r || out_pop);
  assign q_pop = (state_r == ST_IDLE) && !q_empty;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    pos_nxt   = pos_r;
    half_nxt  = half_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          cur_nxt   = q_data;
          pos_nxt   = '0;
          half_nxt  = 1'b0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (emit) begin
          half_nxt = !half_r;
          if (half_r) begin
            pos_nxt = pos_r + 1'b1;
          end
          if (fin) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    ovalid_nxt = ovalid_r;
    if (emit) begin
      ovalid_nxt = 1'b1;
    end else if (out_pop) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    pos_r  <= pos_nxt;
    half_r <= half_nxt;
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (emit) begin
      rs_r   <= cur_r.rs;
      nib_r  <= half_r ? cur_byte[NIB_W-1:0] : cur_byte[BYTE_W-1:NIB_W];
      pre_r  <= (cur_r.init && (pos_r == '0) && !half_r) ? PRE_INIT_MS : PRE_NONE_MS;
      post_r <= (cur_r.init && half_r && (pos_r < INIT_WAKE)) ? POST_WAKE_MS : POST_MS;
      last_r <= fin;
    end
  end

  assign out_empty           = !ovalid_r;
  assign out_register_select = rs_r;
  assign out_nibble          = nib_r;
  assign out_pre_wait_ms     = pre_r;
  assign out_post_wait_ms    = post_r;
  assign out_last            = last_r;

endmodule

### hdl/char_lcd_nibble_sequencer.sv
// top level of the character-lcd 4-bit nibble sequencer
// Each request becomes a run of 4-bit transfers for a character LCD, one
// result per enable pulse: high nibble then low nibble of every byte, with
// the RS level and the millisecond waits before and after the pulse. A
// byte request gives 2 results, a shift request 2 per repetition (up to
// 2*MAX_SHIFT), init gives 20; requests that address nothing are taken and
// dropped. Requests are classified on entry and held in a job queue of
// QUEUE_DEPTH entries, so new requests are taken while a run is still
// going out. The nibble generator sends one result per cycle while the
// result side keeps taking them; it fetches each job from the queue in its
// idle state and takes no new job until the current run is through.
// After reset the block is ready at once.
module char_lcd_nibble_sequencer
  import cln_pkg::*;
#(
  parameter int MAX_SHIFT   = MAX_SHIFT_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [BYTE_W-1:0] in_value,
  input  logic [ROW_W-1:0]  in_row,
  input  logic [COL_W-1:0]  in_column,
  input  logic [CNT_W-1:0]  in_shift_count,
  input  logic              in_direction,
  output logic              out_empty,
  input  logic              out_pop,
  output logic              out_register_select,
  output logic [NIB_W-1:0]  out_nibble,
  output logic [PRE_W-1:0]  out_pre_wait_ms,
  output logic [POST_W-1:0] out_post_wait_ms,
  output logic              out_last
);

  logic  q_push, q_full, q_pop, q_empty;
  desc_t q_wdata, q_rdata;

  // request classification
  cln_front #(
    .MAX_SHIFT(MAX_SHIFT)
  ) u_front (
    .in_push       (in_push),
    .in_full       (in_full),
    .in_command    (in_command),
    .in_value      (in_value),
    .in_row        (in_row),
    .in_column     (in_column),
    .in_shift_count(in_shift_count),
    .in_direction  (in_direction),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_wdata)
  );

  // job queue
  cln_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  // nibble generation
  cln_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_data             (q_rdata),
    .q_pop              (q_pop),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_register_select(out_register_select),
    .out_nibble         (out_nibble),
    .out_pre_wait_ms    (out_pre_wait_ms),
    .out_post_wait_ms   (out_post_wait_ms),
    .out_last           (out_last)
  );

endmodule

### hdl/cln_checker.sv
// port-level checks of the nibble sequencer, bound to the top level
module cln_checker
  import cln_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_empty,
  input logic              out_pop,
  input logic              out_register_select,
  input logic [NIB_W-1:0]  out_nibble,
  input logic [PRE_W-1:0]  out_pre_wait_ms,
  input logic [POST_W-1:0] out_post_wait_ms,
  input logic              out_last
);

  // a waiting result holds until transfer
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_nibble) &&
      $stable(out_register_select) && $stable(out_last) &&
      $stable(out_pre_wait_ms) && $stable(out_post_wait_ms)))
    else $error("result changed while waiting");

  // nothing waits right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result present after reset");

  // only the first init nibble has a lead-in wait
  a_pre: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_pre_wait_ms != PRE_NONE_MS)) |->
      (out_pre_wait_ms == PRE_INIT_MS && out_nibble == 4'h0 &&
       !out_register_select && !out_last))
    else $error("bad lead-in wait");

  // long post wait only on the low nibble of a wake-up byte
  a_post: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_post_wait_ms == POST_MS ||
      (out_post_wait_ms == POST_WAKE_MS && out_nibble == 4'h3 &&
       !out_register_select && !out_last)))
    else $error("bad post wait");

  // data nibbles carry only the plain waits
  a_data: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_register_select) |->
      (out_pre_wait_ms == PRE_NONE_MS && out_post_wait_ms == POST_MS))
    else $error("bad waits on data nibble");

endmodule

bind char_lcd_nibble_sequencer cln_checker u_cln_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_empty          (out_empty),
  .out_pop            (out_pop),
  .out_register_select(out_register_select),
  .out_nibble         (out_nibble),
  .out_pre_wait_ms    (out_pre_wait_ms),
  .out_post_wait_ms   (out_post_wait_ms),
  .out_last           (out_last)
);

### verif/lcd_nibble_checker.sv
// nibble predictor and result checker for the character-lcd nibble sequencer
module lcd_nibble_checker
  import cln_pkg::*;
#(
  parameter int MAX_SHIFT = MAX_SHIFT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic              in_full,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [BYTE_W-1:0] in_value,
  input  logic [ROW_W-1:0]  in_row,
  input  logic [COL_W-1:0]  in_column,
  input  logic [CNT_W-1:0]  in_shift_count,
  input  logic              in_direction,
  input  logic              out_empty,
  input  logic              out_pop,
  input  logic              out_register_select,
  input  logic [NIB_W-1:0]  out_nibble,
  input  logic [PRE_W-1:0]  out_pre_wait_ms,
  input  logic [POST_W-1:0] out_post_wait_ms,
  input  logic              out_last,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic RS_INSTR = 1'b0;
  localparam logic RS_DATA  = 1'b1;

  // wake-up byte sent four times at the start of init
  localparam logic [BYTE_W-1:0] LCD_WAKE = 8'h03;
  localparam int WAKE_REPS  = 4;
  localparam int SETUP_REPS = 6;

  typedef struct packed {
    logic              rs;
    logic [NIB_W-1:0]  nib;
    logic [PRE_W-1:0]  pre;
    logic [POST_W-1:0] post;
    logic              last;
  } nibble_t;

  nibble_t expected_nibbles[$];

  // setup bytes that follow the wake-up bytes, in sending order
  function automatic logic [BYTE_W-1:0] setup_byte(input int idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      0:       b = 8'h02;
      1:       b = 8'h28;
      2:       b = 8'h08;
      3:       b = 8'h0F;
      4:       b = 8'h06;
      default: b = 8'h01;
    endcase
    return b;
  endfunction

  task automatic queue_nibble(input logic rs, input logic [NIB_W-1:0] nib,
                              input logic [PRE_W-1:0] pre, input logic [POST_W-1:0] post);
    nibble_t n;
    n.rs   = rs;
    n.nib  = nib;
    n.pre  = pre;
    n.post = post;
    n.last = 1'b0;
    expected_nibbles.push_back(n);
  endtask

  // high nibble first, low nibble carries the post wait of the byte
  task automatic queue_byte(input logic rs, input logic [BYTE_W-1:0] data_byte,
                            input logic [PRE_W-1:0] pre, input logic [POST_W-1:0] post_low);
    queue_nibble(rs, data_byte[7:4], pre, POST_MS);
    queue_nibble(rs, data_byte[3:0], PRE_NONE_MS, post_low);
  endtask

  // expand one request into the nibbles it should produce
  task automatic expand_request(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] value,
                                input logic [ROW_W-1:0] row, input logic [COL_W-1:0] column,
                                input logic [CNT_W-1:0] count, input logic dir);
    int start_n;
    int reps;
    logic [BYTE_W-1:0] addr;
    nibble_t tail;
    start_n = expected_nibbles.size();
    case (cmd)
      CMD_INSTR: queue_byte(RS_INSTR, value, PRE_NONE_MS, POST_MS);
      CMD_DATA:  queue_byte(RS_DATA, value, PRE_NONE_MS, POST_MS);
      CMD_CURSOR: begin
        // rows other than the two display rows address nothing
        if (row == ROW_FIRST || row == ROW_SECOND) begin
          addr = {2'b00, column} - 8'd1;
          if (row == ROW_SECOND) addr = addr + LCD_ROW2_OFS;
          queue_byte(RS_INSTR, LCD_SET_DDRAM | addr, PRE_NONE_MS, POST_MS);
        end
      end
      CMD_CLEAR: queue_byte(RS_INSTR, LCD_CLEAR, PRE_NONE_MS, POST_MS);
      CMD_SHIFT: begin
        reps = (count > MAX_SHIFT) ? MAX_SHIFT : int'(count);
        for (int i = 0; i < reps; i++)
          queue_byte(RS_INSTR, LCD_SHIFT_BASE | {5'b00000, dir, 2'b00}, PRE_NONE_MS, POST_MS);
      end
      CMD_INIT: begin
        for (int i = 0; i < WAKE_REPS; i++)
          queue_byte(RS_INSTR, LCD_WAKE, (i == 0) ? PRE_INIT_MS : PRE_NONE_MS, POST_WAKE_MS);
        for (int i = 0; i < SETUP_REPS; i++)
          queue_byte(RS_INSTR, setup_byte(i), PRE_NONE_MS, POST_MS);
      end
      default: ;
    endcase
    // flag the final nibble of the run
    if (expected_nibbles.size() > start_n) begin
      tail = expected_nibbles.pop_back();
      tail.last = 1'b1;
      expected_nibbles.push_back(tail);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // compare result transfers first, then predict from request transfers
  always @(posedge clk) begin
    nibble_t want;
    if (!rst_n) begin
      fail_count = 0;
      expected_nibbles.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_nibbles.size() == 0) begin
          $display({"%0t: unexpected nibble, expected none, ",
                    "actual rs=%0b nibble=%h pre=%0d post=%0d last=%0b"},
                   $time, out_register_select, out_nibble, out_pre_wait_ms,
                   out_post_wait_ms, out_last);
          fail_count++;
        end else begin
          want = expected_nibbles.pop_front();
          check_field("register_select", 32'(want.rs), 32'(out_register_select));
          check_field("nibble", 32'(want.nib), 32'(out_nibble));
          check_field("pre_wait_ms", 32'(want.pre), 32'(out_pre_wait_ms));
          check_field("post_wait_ms", 32'(want.post), 32'(out_post_wait_ms));
          check_field("last", 32'(want.last), 32'(out_last));
        end
      end
      if (in_push && !in_full)
        expand_request(in_command, in_value, in_row, in_column, in_shift_count, in_direction);
    end
    pending = expected_nibbles.size();
  end

endmodule

### verif/tb_char_lcd_nibble_sequencer.sv
// stimulus and verdict for the character-lcd nibble sequencer
module tb_char_lcd_nibble_sequencer;
  timeunit 1ns;
  timeprecision 1ps;
  import cln_pkg::*;

  // request codes the block does not define
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  localparam int RANDOM_ITEMS  = 200;
  localparam int QUIET_TAIL    = 40;
  localparam int SETTLE_CYCLES = 80;
  localparam int STALL_LIMIT   = 2000;

  logic              clk;
  logic              rst_n;
  logic              in_push;
  logic              in_full;
  logic [CMD_W-1:0]  in_command;
  logic [BYTE_W-1:0] in_value;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_column;
  logic [CNT_W-1:0]  in_shift_count;
  logic              in_direction;
  logic              out_empty;
  logic              out_pop;
  logic              out_register_select;
  logic [NIB_W-1:0]  out_nibble;
  logic [PRE_W-1:0]  out_pre_wait_ms;
  logic [POST_W-1:0] out_post_wait_ms;
  logic              out_last;
  int                fail_count;
  int                pending;
  logic              idle_on;

  char_lcd_nibble_sequencer uut (.*);

  lcd_nibble_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // request transfer, with an occasional idle burst ahead of it
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] value,
                              input logic [ROW_W-1:0] row, input logic [COL_W-1:0] column,
                              input logic [CNT_W-1:0] count, input logic dir);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_command     <= cmd;
    in_value       <= value;
    in_row         <= row;
    in_column      <= column;
    in_shift_count <= count;
    in_direction   <= dir;
    in_push        <= 1'b1;
    do @(negedge clk); while (in_full);
    @(posedge clk);
  endtask

  // hold off requests until every predicted nibble has been taken
  task automatic drain_results();
    in_push <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // result side: pop with random stall bursts while idling is on
  initial begin
    int stall_left;
    stall_left = 0;
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) stuck = 0;
      else stuck++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int pick;
    logic [CMD_W-1:0]  cmd;
    logic [COL_W-1:0]  column;
    logic [CNT_W-1:0]  count;
    idle_on        = 1'b1;
    rst_n          <= 1'b0;
    in_push        <= 1'b0;
    in_command     <= CMD_INSTR;
    in_value       <= '0;
    in_row         <= '0;
    in_column      <= '0;
    in_shift_count <= '0;
    in_direction   <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: byte extremes, cursor corners, shift limits, init, spare codes
    send_request(CMD_INSTR,  8'h00, 2'd0, 6'd1,  6'd0,  1'b0);
    send_request(CMD_INSTR,  8'hFF, 2'd3, 6'd63, 6'd63, 1'b1);
    send_request(CMD_DATA,   8'h00, 2'd1, 6'd5,  6'd3,  1'b0);
    send_request(CMD_DATA,   8'hFF, 2'd2, 6'd9,  6'd1,  1'b1);
    send_request(CMD_DATA,   8'hA5, 2'd1, 6'd1,  6'd0,  1'b0);
    send_request(CMD_CURSOR, 8'h00, 2'd1, 6'd1,  6'd0,  1'b0);
    send_request(CMD_CURSOR, 8'h00, 2'd1, 6'd40, 6'd0,  1'b0);
    send_request(CMD_CURSOR, 8'h00, 2'd2, 6'd1,  6'd0,  1'b0);
    send_request(CMD_CURSOR, 8'h00, 2'd2, 6'd40, 6'd0,  1'b0);
    // rows that address nothing
    send_request(CMD_CURSOR, 8'hFF, 2'd0, 6'd7,  6'd0,  1'b0);
    send_request(CMD_CURSOR, 8'hFF, 2'd3, 6'd7,  6'd0,  1'b0);
    // column zero and columns beyond the display wrap
    send_request(CMD_CURSOR, 8'h00, 2'd1, 6'd0,  6'd0,  1'b0);
    send_request(CMD_CURSOR, 8'h00, 2'd2, 6'd0,  6'd0,  1'b0);
    send_request(CMD_CURSOR, 8'h00, 2'd2, 6'd63, 6'd0,  1'b0);
    send_request(CMD_CLEAR,  8'h3C, 2'd0, 6'd0,  6'd0,  1'b0);
    send_request(CMD_SHIFT,  8'h00, 2'd0, 6'd1,  6'd0,  1'b1);
    send_request(CMD_SHIFT,  8'h00, 2'd0, 6'd1,  6'd1,  1'b0);
    send_request(CMD_SHIFT,  8'h00, 2'd0, 6'd1,  6'd1,  1'b1);
    send_request(CMD_SHIFT,  8'h00, 2'd0, 6'd1,  6'd32, 1'b0);
    // shift count above the maximum saturates
    send_request(CMD_SHIFT,  8'h00, 2'd0, 6'd1,  6'd63, 1'b1);
    send_request(CMD_INIT,   8'h00, 2'd0, 6'd1,  6'd0,  1'b0);
    send_request(CMD_SPARE_A, 8'h55, 2'd1, 6'd3, 6'd4,  1'b0);
    send_request(CMD_SPARE_B, 8'hAA, 2'd2, 6'd3, 6'd4,  1'b1);
    drain_results();

    // random requests, mostly well-formed with small shift counts
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_on = (i < RANDOM_ITEMS - QUIET_TAIL) && (i % 50 < 35);
      if (i == RANDOM_ITEMS / 2) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 20)      cmd = CMD_INSTR;
      else if (pick < 40) cmd = CMD_DATA;
      else if (pick < 60) cmd = CMD_CURSOR;
      else if (pick < 68) cmd = CMD_CLEAR;
      else if (pick < 85) cmd = CMD_SHIFT;
      else if (pick < 91) cmd = CMD_INIT;
      else if (pick < 96) cmd = CMD_SPARE_A;
      else                cmd = CMD_SPARE_B;
      column = ($urandom_range(0, 99) < 85) ? COL_W'($urandom_range(1, 40))
                                            : COL_W'($urandom_range(0, 63));
      count  = ($urandom_range(0, 99) < 80) ? CNT_W'($urandom_range(0, 6))
                                            : CNT_W'($urandom_range(0, 63));
      send_request(cmd, BYTE_W'($urandom_range(0, 255)), ROW_W'($urandom_range(0, 3)),
                   column, count, 1'($urandom_range(0, 1)));
    end
    idle_on = 1'b0;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (pending != 0)
      $display("%0t: %0d expected nibbles never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
